FILE: rtl/utrq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utrq_pkg
// Shared types and constants for the transmit ring queue.
// ----------------------------------------------------------------------------
package utrq_pkg;

  localparam int unsigned FREE_W = 7;
  localparam logic [7:0] OVERFLOW_MARK = 8'h21;

  localparam logic MODE_PUSH  = 1'b0;
  localparam logic MODE_EMPTY = 1'b1;

  typedef struct packed {
    logic       mode;
    logic [7:0] char_in;
  } in_item_t;

  typedef struct packed {
    logic              accepted;
    logic              tx_valid;
    logic [7:0]        tx_byte;
    logic              tx_busy;
    logic [FREE_W-1:0] free_slots;
  } out_item_t;

  typedef struct packed {
    logic exec;
    logic start_read;
    logic finish_read;
  } utrq_cmd_t;

  typedef struct packed {
    logic empty;
    logic slot_free;
  } utrq_status_t;

endpackage

FILE: rtl/utrq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utrq_ctrl
// Controller: accepts items and sequences the store read for events.
// ----------------------------------------------------------------------------
module utrq_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_mode,
  input  utrq_pkg::utrq_status_t status,
  output utrq_pkg::utrq_cmd_t    cmd,
  output logic                  in_stall
);
  import utrq_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_READ = 1'b1;

  logic state_r;
  logic state_nxt;
  logic take;

  assign in_stall = !((state_r == ST_IDLE) && status.slot_free);
  assign take     = in_valid && !in_stall;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (take) begin
          if ((in_mode == MODE_EMPTY) && !status.empty) begin
            cmd.start_read = 1'b1;
            state_nxt      = ST_READ;
          end else begin
            cmd.exec = 1'b1;
          end
        end
      end
      ST_READ: begin
        cmd.finish_read = 1'b1;
        state_nxt       = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: rtl/utrq_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utrq_dp
// Datapath: byte store, ring indices, fill count, busy flag, result register.
// ----------------------------------------------------------------------------
module utrq_dp #(
  parameter int unsigned QUEUE_DEPTH = 128
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  utrq_pkg::in_item_t     in_data,
  input  utrq_pkg::utrq_cmd_t    cmd,
  output utrq_pkg::utrq_status_t status,
  output logic                   out_valid,
  input  logic                   out_stall,
  output utrq_pkg::out_item_t    out_data
);
  import utrq_pkg::*;

  localparam int unsigned IW = $clog2(QUEUE_DEPTH);
  localparam logic [IW-1:0] MAX_CNT  = IW'(QUEUE_DEPTH - 1);
  localparam logic [IW-1:0] LAST_IDX = IW'(QUEUE_DEPTH - 1);

  logic [7:0]    mem [QUEUE_DEPTH];
  logic [7:0]    rd_data_r;
  logic [IW-1:0] wr_idx_r, wr_idx_nxt;
  logic [IW-1:0] rd_idx_r, rd_idx_nxt;
  logic [IW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          out_valid_r, out_valid_nxt;
  out_item_t     out_data_r;
  out_item_t     res;
  logic          load;
  logic          mem_we;
  logic [7:0]    stored;

  function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] idx);
    logic [IW-1:0] r;
    r = (idx == LAST_IDX) ? '0 : idx + 1'b1;
    return r;
  endfunction

  assign stored = (cnt_r == MAX_CNT - 1'b1) ? OVERFLOW_MARK : in_data.char_in;

  always_comb begin
    wr_idx_nxt = wr_idx_r;
    rd_idx_nxt = rd_idx_r;
    cnt_nxt    = cnt_r;
    busy_nxt   = busy_r;
    mem_we     = 1'b0;
    load       = 1'b0;
    res        = '0;
    if (cmd.exec) begin
      load = 1'b1;
      if (in_data.mode == MODE_PUSH) begin
        if (cnt_r != MAX_CNT) begin
          mem_we       = 1'b1;
          res.accepted = (cnt_r != MAX_CNT - 1'b1);
          wr_idx_nxt   = wrap_inc(wr_idx_r);
          if (!busy_r) begin
            res.tx_valid = 1'b1;
            res.tx_byte  = stored;
            rd_idx_nxt   = wrap_inc(rd_idx_r);
          end else begin
            cnt_nxt = cnt_r + 1'b1;
          end
          busy_nxt = 1'b1;
        end
      end else begin
        busy_nxt = 1'b0;
      end
    end
    if (cmd.finish_read) begin
      load         = 1'b1;
      res.tx_valid = 1'b1;
      res.tx_byte  = rd_data_r;
      rd_idx_nxt   = wrap_inc(rd_idx_r);
      cnt_nxt      = cnt_r - 1'b1;
    end
    res.tx_busy    = busy_nxt;
    res.free_slots = FREE_W'(MAX_CNT - cnt_nxt);
  end

  assign out_valid_nxt = load || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_idx_r] <= stored;
    end
    rd_data_r <= mem[rd_idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_idx_r    <= '0;
      rd_idx_r    <= '0;
      cnt_r       <= '0;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      wr_idx_r    <= wr_idx_nxt;
      rd_idx_r    <= rd_idx_nxt;
      cnt_r       <= cnt_nxt;
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r <= res;
    end
  end

  assign status.empty     = (cnt_r == '0);
  assign status.slot_free = !out_valid_r || !out_stall;
  assign out_valid        = out_valid_r;
  assign out_data         = out_data_r;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= MAX_CNT) else $error("fill count beyond capacity");

  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> cnt_r == '0) else $error("bytes queued while transmitter idle");

  a_hand_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.tx_valid |-> out_data_r.tx_busy)
    else $error("byte handed out without busy set");

  a_read_done: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish_read |-> !out_valid_r && $past(cmd.start_read))
    else $error("store read finished without a free result slot");
`endif

endmodule

FILE: rtl/uart_tx_ring_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uart_tx_ring_queue
// Transmit character ring queue in front of a UART shifter.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall/in_data): a push of char_in (mode 0) or a
// transmitter-empty event (mode 1). A transfer happens when in_valid is high
// and in_stall is low. Each item gives exactly one result on the out_ channel.
// A push, and an event on an empty queue, shows its result in the cycle after
// the transfer; a new item can follow in the next cycle, so these run at one
// item per cycle while out_stall is low. An event that hands out a queued byte
// needs the registered read port of the byte store: the byte passes the read
// and result registers, and in_stall stays high in the read state meanwhile.
// The result register holds while out_stall is high; in_stall then rises
// until the result is taken. Reset empties the queue (indices and fill count
// cleared) and clears the busy flag; the byte store itself is not cleared.
// ----------------------------------------------------------------------------
module uart_tx_ring_queue #(
  parameter int unsigned QUEUE_DEPTH = 128
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  utrq_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output utrq_pkg::out_item_t out_data
);
  import utrq_pkg::*;

  utrq_cmd_t    cmd;
  utrq_status_t status;

  utrq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_mode  (in_data.mode),
    .status   (status),
    .cmd      (cmd),
    .in_stall (in_stall)
  );

  utrq_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

FILE: verif/utrq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utrq_checker
// Watches both channels of the transmit ring queue, keeps its own copy of
// the ring, indices and busy flag, works out the result of every input
// transfer and compares each result transfer, field by field, in order.
// ----------------------------------------------------------------------------
module utrq_checker #(
  parameter int unsigned QUEUE_DEPTH = 128
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_stall,
  input  utrq_pkg::in_item_t  in_data,
  input  logic                out_valid,
  input  logic                out_stall,
  input  utrq_pkg::out_item_t out_data,
  output int                  fail_count,
  output int                  pending_count
);
  import utrq_pkg::*;

  logic [7:0]  ring [QUEUE_DEPTH];
  int unsigned wr_idx;
  int unsigned rd_idx;
  logic        busy_q;
  out_item_t   queued_reports[$];
  out_item_t   want;
  int          err_total = 0;

  function automatic int unsigned step_index(int unsigned idx);
    return (idx + 1 == QUEUE_DEPTH) ? 0 : idx + 1;
  endfunction

  function automatic int unsigned free_room();
    int unsigned held;
    held = (wr_idx >= rd_idx) ? wr_idx - rd_idx : QUEUE_DEPTH - rd_idx + wr_idx;
    return QUEUE_DEPTH - 1 - held;
  endfunction

  function automatic logic [7:0] pop_oldest();
    logic [7:0] b;
    b = ring[rd_idx];
    rd_idx = step_index(rd_idx);
    return b;
  endfunction

  function automatic out_item_t advance_tx_queue(in_item_t item);
    out_item_t   r;
    int unsigned room;
    logic [7:0]  stored;
    r = '0;
    if (item.mode == MODE_PUSH) begin
      room = free_room();
      if (room >= 1) begin
        stored = item.char_in;
        if (room == 1) begin
          stored = OVERFLOW_MARK;
        end else begin
          r.accepted = 1'b1;
        end
        ring[wr_idx] = stored;
        wr_idx = step_index(wr_idx);
        if (!busy_q) begin
          r.tx_byte = pop_oldest();
          r.tx_valid = 1'b1;
        end
        busy_q = 1'b1;
      end
    end else if (wr_idx == rd_idx) begin
      busy_q = 1'b0;
    end else begin
      r.tx_byte = pop_oldest();
      r.tx_valid = 1'b1;
    end
    r.tx_busy = busy_q;
    r.free_slots = FREE_W'(free_room());
    return r;
  endfunction

  function automatic void check_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
      err_total++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      wr_idx = 0;
      rd_idx = 0;
      busy_q = 1'b0;
      queued_reports.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (queued_reports.size() == 0) begin
          $display("%0t: result with none expected, expected nothing, actual %h",
                   $time, out_data);
          err_total++;
        end else begin
          want = queued_reports.pop_front();
          check_field("accepted", want.accepted, out_data.accepted);
          check_field("tx_valid", want.tx_valid, out_data.tx_valid);
          check_field("tx_byte", want.tx_byte, out_data.tx_byte);
          check_field("tx_busy", want.tx_busy, out_data.tx_busy);
          check_field("free_slots", want.free_slots, out_data.free_slots);
        end
      end
      if (in_valid && !in_stall) begin
        queued_reports.push_back(advance_tx_queue(in_data));
      end
    end
    pending_count <= queued_reports.size();
    fail_count <= err_total;
  end

endmodule

FILE: verif/uart_tx_ring_queue_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uart_tx_ring_queue_tb
// Drives pushes and transmitter-empty events into the transmit ring queue:
// a directed opening over idle, busy and empty cases, then random fill,
// drain and mixed stretches that run the queue into its overflow marker and
// full states. Both sides idle at random; a checker scores every result.
// ----------------------------------------------------------------------------
module uart_tx_ring_queue_tb;
  import utrq_pkg::*;

  localparam int unsigned QUEUE_DEPTH = 128;
  localparam int          CYCLE_LIMIT = 200000;
  localparam int          ITEM_TARGET = 450;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;
  int        fail_count;
  int        pending_count;
  int        cycles = 0;
  int        hold_left = 0;
  int        sent = 0;
  int        stretch_len = 0;
  bit        in_calm = 1'b0;
  bit        out_calm = 1'b0;

  uart_tx_ring_queue #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  utrq_checker #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data),
    .fail_count   (fail_count),
    .pending_count(pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("uart_tx_ring_queue_tb: FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= (hold_left > 1);
    end else if (out_valid && !out_stall) begin
      automatic int w = out_calm ? 0 : $urandom_range(0, 8);
      if ($urandom_range(0, 19) == 0) out_calm = !out_calm;
      hold_left <= w;
      out_stall <= (w != 0);
    end
  end

  task automatic send_item(logic mode, logic [7:0] ch);
    int unsigned gap;
    gap = in_calm ? 0 : $urandom_range(0, 8);
    if ($urandom_range(0, 19) == 0) in_calm = !in_calm;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= {mode, ch};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  // weight is the share of pushes out of 32
  task automatic run_stretch(int unsigned len, int unsigned weight);
    repeat (len) begin
      if ($urandom_range(0, 31) < weight) begin
        send_item(MODE_PUSH, 8'($urandom_range(0, 255)));
      end else begin
        send_item(MODE_EMPTY, 8'($urandom_range(0, 255)));
      end
    end
  endtask

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    send_item(MODE_EMPTY, 8'hFF);
    send_item(MODE_PUSH, 8'h00);
    send_item(MODE_PUSH, 8'hFF);
    send_item(MODE_PUSH, OVERFLOW_MARK);
    send_item(MODE_PUSH, 8'h55);
    send_item(MODE_EMPTY, 8'h00);
    send_item(MODE_EMPTY, 8'hAA);
    send_item(MODE_EMPTY, 8'h00);
    send_item(MODE_EMPTY, 8'h00);
    send_item(MODE_EMPTY, 8'h00);
    send_item(MODE_PUSH, 8'hAA);
    send_item(MODE_EMPTY, 8'h00);
    send_item(MODE_PUSH, 8'h7F);
    send_item(MODE_PUSH, 8'h80);
    send_item(MODE_EMPTY, 8'h00);

    // fill past the overflow marker into the full state, then drain
    run_stretch(175, 31);
    run_stretch(40, 4);
    while (sent < ITEM_TARGET) begin
      stretch_len = int'($urandom_range(20, 160));
      if (sent + stretch_len > ITEM_TARGET) stretch_len = ITEM_TARGET - sent;
      case ($urandom_range(0, 2))
        0:       run_stretch(stretch_len, 31);
        1:       run_stretch(stretch_len, 4);
        default: run_stretch(stretch_len, 16);
      endcase
    end

    in_valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("uart_tx_ring_queue_tb: PASS");
    end else begin
      $display("uart_tx_ring_queue_tb: FAIL");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/utrq_pkg.sv
rtl/utrq_ctrl.sv
rtl/utrq_dp.sv
rtl/uart_tx_ring_queue.sv
verif/utrq_checker.sv
verif/uart_tx_ring_queue_tb.sv
